// ----- rtl/apc_pkg.sv -----
package apc_pkg;

  // Field and register widths
  localparam int ANG_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int ERR_W      = 18;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Serial divider: (limit << 8) / integ_gain, one quotient bit per cycle
  localparam int DIVD_W     = LIM_W + 8;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Shared multiplier: gain (zero-extended) times a signed operand
  localparam int MULA_W     = GAIN_W + 1;
  localparam int MULB_W     = DIVD_W + 2;
  localparam int PROD_W     = MULA_W + MULB_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int DRV_W      = ACC_W - 8;

  // Angle constants in Q3.12
  localparam logic signed [ERR_W-1:0] ANG_PI     = 18'sd12868;
  localparam logic signed [ERR_W-1:0] ANG_TWO_PI = 18'sd25736;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PROP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 8'd3;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_CLEAR   = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_ERR,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_CLAMP,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_in;
    logic     clear;
    logic     calc_err;
    logic     calc_sum;
    logic     div_init;
    logic     div_step;
    logic     clamp;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     finish;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic opcode_clr;
    logic ki_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/apc_ctrl.sv -----
module apc_ctrl import apc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.opcode_clr ? S_CLR : S_ERR;
        end
      end
      S_CLR:      state_nxt = S_OUT;
      S_ERR:      state_nxt = S_SUM;
      S_SUM:      state_nxt = stat.ki_zero ? S_CLAMP : S_DIV_INIT;
      S_DIV_INIT: begin
        state_nxt   = S_DIV;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CLAMP;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      S_CLAMP:    state_nxt = S_MUL_P;
      S_MUL_P:    state_nxt = S_MUL_I;
      S_MUL_I:    state_nxt = S_MUL_D;
      S_MUL_D:    state_nxt = S_ACC;
      S_ACC:      state_nxt = S_FIN;
      S_FIN:      state_nxt = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_P;
    cmd.acc_op  = ACC_HOLD;
    case (state_r)
      S_IDLE:     cmd.load_in  = in_valid;
      S_CLR:      cmd.clear    = 1'b1;
      S_ERR:      cmd.calc_err = 1'b1;
      S_SUM:      cmd.calc_sum = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_CLAMP:    cmd.clamp    = 1'b1;
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_op  = ACC_LOAD;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_op  = ACC_ADD;
      end
      S_ACC:      cmd.acc_op   = ACC_ADD;
      S_FIN:      cmd.finish   = 1'b1;
      S_OUT:      cmd.out_load = stat.out_free;
      default:    cmd          = '0;
    endcase
  end

  // Divider step count never runs past the quotient width
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("divider step counter overran");

  // An accepted transaction starts either a clear or an error computation
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CLR || state_r == S_ERR))
    else $error("accepted transaction did not start processing");

endmodule

// ----- rtl/apc_dp.sv -----
module apc_dp import apc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  logic                  in_opcode,
  input  logic [ANG_W-1:0]      in_target,
  input  logic [ANG_W-1:0]      in_measured,
  // result stage
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [ANG_W-1:0]      out_drive,
  // control
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIM_W-1:0]  drive_limit_r;

  // Loop state and working registers
  logic signed [ANG_W-1:0]  target_r, measured_r;
  logic signed [ERR_W-1:0]  e_r, last_error_r;
  logic signed [SUM_W-1:0]  error_sum_r, sum_r;
  logic [GAIN_W-1:0]        rem_r;
  logic [DIVD_W-1:0]        quo_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ANG_W-1:0]  res_r;
  logic                     out_valid_r;
  logic [ANG_W-1:0]         out_data_r;

  // Combinational intermediates
  logic signed [ERR_W-1:0]  diff, e_nxt;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_nxt, clamp_nxt;
  logic signed [SUM_W:0]    imax, imin;
  logic [GAIN_W:0]          trial, trial_sub;
  logic signed [ERR_W:0]    ddiff;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [DRV_W-1:0]  drv, lim_s;
  logic signed [ANG_W-1:0]  res_nxt;

  assign stat.opcode_clr = (opcode_t'(in_opcode) == OP_CLEAR);
  assign stat.ki_zero    = (integ_gain_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_drive = out_data_r;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      drive_limit_r <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP:  prop_gain_r   <= cfg_data;
        REG_INTEG: integ_gain_r  <= cfg_data;
        REG_DERIV: deriv_gain_r  <= cfg_data;
        REG_LIMIT: drive_limit_r <= cfg_data[LIM_W-1:0];
        default:   ;
      endcase
    end
  end

  // Error, wrapped once by two pi
  always_comb begin
    diff = ERR_W'(target_r) - ERR_W'(measured_r);
    if (diff > ANG_PI) begin
      e_nxt = diff - ANG_TWO_PI;
    end else if (diff < -ANG_PI) begin
      e_nxt = diff + ANG_TWO_PI;
    end else begin
      e_nxt = diff;
    end
  end

  // Saturating integral
  always_comb begin
    sum_wide = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(e_r);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  // Integral clamp against the divider quotient
  always_comb begin
    imax = $signed({{(SUM_W+1-DIVD_W){1'b0}}, quo_r});
    imin = -imax;
    clamp_nxt = sum_r;
    if (!stat.ki_zero) begin
      if ((SUM_W+1)'(sum_r) > imax) begin
        clamp_nxt = imax[SUM_W-1:0];
      end else if ((SUM_W+1)'(sum_r) < imin) begin
        clamp_nxt = imin[SUM_W-1:0];
      end
    end
  end

  // Restoring divider step
  assign trial     = {rem_r, quo_r[DIVD_W-1]};
  assign trial_sub = trial - {1'b0, integ_gain_r};

  // Shared multiplier operands
  assign ddiff = (ERR_W+1)'(e_r) - (ERR_W+1)'(last_error_r);
  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, prop_gain_r});
        mul_b = MULB_W'(e_r);
      end
      MUL_I: begin
        mul_a = $signed({1'b0, integ_gain_r});
        mul_b = sum_r[MULB_W-1:0];
      end
      MUL_D: begin
        mul_a = $signed({1'b0, deriv_gain_r});
        mul_b = MULB_W'(ddiff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift and output clamp
  always_comb begin
    drv   = acc_r[ACC_W-1:8];
    lim_s = $signed({{(DRV_W-LIM_W){1'b0}}, drive_limit_r});
    if (drv > lim_s) begin
      res_nxt = lim_s[ANG_W-1:0];
    end else if (drv < -lim_s) begin
      res_nxt = ANG_W'(-lim_s);
    end else begin
      res_nxt = drv[ANG_W-1:0];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target_r   <= in_target;
      measured_r <= in_measured;
    end
    if (cmd.calc_err) begin
      e_r <= e_nxt;
    end
    if (cmd.calc_sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= {drive_limit_r, 8'b0};
    end else if (cmd.div_step) begin
      if (!trial_sub[GAIN_W]) begin
        rem_r <= trial_sub[GAIN_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[GAIN_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], 1'b0};
      end
    end
    if (cmd.clamp) begin
      sum_r <= clamp_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      default:  ;
    endcase
    if (cmd.finish) begin
      res_r <= res_nxt;
    end else if (cmd.clear) begin
      res_r <= '0;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (cmd.clear) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      if (cmd.clamp) begin
        error_sum_r <= clamp_nxt;
      end
      if (cmd.finish) begin
        last_error_r <= e_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A clear leaves the loop state at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (error_sum_r == '0 && last_error_r == '0))
    else $error("loop state not cleared");

  // Single wrap keeps the error inside plus or minus 39799, just over three pi
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_err |=> (e_r <= 18'sd39799 && e_r >= -18'sd39799))
    else $error("wrapped error out of range");

  // A new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

// ----- rtl/angle_pid_controller_unit.sv -----
// Angle PID controller with anti-windup, fixed point.
// Input stream: in_tdata carries target and measured angles (signed Q3.12),
// in_tuser carries the opcode (0 = compute step, 1 = clear loop state).
// Output stream: out_tdata carries the clamped drive, signed Q3.12.
// Configuration: cfg_index selects prop_gain (0), integ_gain (1),
// deriv_gain (2) or drive_limit (3); other indexes are ignored. Write only
// while no transaction is in flight.
// Sequence: a clear goes from S_CLR straight to S_OUT. A compute step with
// integ_gain nonzero adds, over one with integ_gain zero, the divider setup
// plus 23 bit-serial steps forming the integral limit
// (drive_limit << 8) / integ_gain. Products go through one shared 17x25
// multiplier, three in a row.
// Flow control: one transaction at a time; in_tready is high only while the
// controller is idle. A new transaction is taken while a result still waits.
// Reset: loop state cleared, gains zero, drive_limit 32767, output empty.
// Stall: a result waits in the output register; the controller holds
// before loading the next result until out_tready frees the register.
module angle_pid_controller_unit import apc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*ANG_W-1:0]    in_tdata,   // [15:0] target_angle, [31:16] measured_angle
  input  logic [0:0]            in_tuser,   // [0] opcode
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ANG_W-1:0]      out_tdata,  // [15:0] drive
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  apc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, loop state and output register
  apc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_opcode   (in_tuser[0]),
    .in_target   (in_tdata[ANG_W-1:0]),
    .in_measured (in_tdata[2*ANG_W-1:ANG_W]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_drive   (out_tdata),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
